// File: design/sorted_reminder_table_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the sorted reminder table
// Shorthand for clocked implication checks with active-low reset masking.
// ----------------------------------------------------------------------------
`ifndef SORTED_REMINDER_TABLE_ASSERT_SVH
`define SORTED_REMINDER_TABLE_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define SRT_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("srt: same-cycle check failed");

// Consequent checked in the cycle after the antecedent.
`define SRT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("srt: next-cycle check failed");

`endif

// File: design/srt_pkg.sv
// ----------------------------------------------------------------------------
// srt_pkg
// Sizes, field types, codes and record layouts of the sorted reminder table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package srt_pkg;

    localparam int MAX_ENTRIES = 64;
    localparam int MAX_MSG     = 60;

    localparam int IDX_W     = $clog2(MAX_ENTRIES);
    localparam int CNT_W     = $clog2(MAX_ENTRIES + 1);
    localparam int BP_W      = $clog2(MAX_MSG + 1);
    localparam int MSG_DEPTH = MAX_ENTRIES * MAX_MSG;
    localparam int MADDR_W   = $clog2(MSG_DEPTH);

    localparam int DAY_W  = 5;
    localparam int BYTE_W = 8;
    localparam int POS_W  = 6;
    localparam int STAT_W = 2;
    localparam int ECNT_W = 7;

    typedef logic [IDX_W-1:0]   t_idx;
    typedef logic [CNT_W-1:0]   t_cnt;
    typedef logic [BP_W-1:0]    t_bp;
    typedef logic [MADDR_W-1:0] t_maddr;
    typedef logic [DAY_W-1:0]   t_day;
    typedef logic [BYTE_W-1:0]  t_byte;
    typedef logic [POS_W-1:0]   t_pos;
    typedef logic [STAT_W-1:0]  t_stat;
    typedef logic [ECNT_W-1:0]  t_ecnt;

    localparam logic FUNC_INSERT = 1'b0;
    localparam logic FUNC_READ   = 1'b1;

    localparam t_stat STAT_OK       = 2'd0;
    localparam t_stat STAT_BAD_DAY  = 2'd1;
    localparam t_stat STAT_FULL     = 2'd2;
    localparam t_stat STAT_NO_ENTRY = 2'd3;

    localparam t_cnt COUNT_FULL = t_cnt'(MAX_ENTRIES);
    localparam t_bp  MSG_CAP    = t_bp'(MAX_MSG);
    localparam t_day DAY_NONE   = t_day'(0);

    // One sorted-order record: slot number plus the day and length it carries
    typedef struct packed {
        t_idx slot;
        t_day day;
        t_bp  len;
    } t_order_entry;

    typedef struct packed {
        t_stat status;
        t_day  day;
        t_byte data;
        logic  has;
        logic  last;
    } t_result;

endpackage

// File: design/srt_in_if.sv
// ----------------------------------------------------------------------------
// srt_in_if
// Input channel: insert bytes and read requests with valid/ready handshake.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface srt_in_if;
    logic                valid;
    logic                ready;
    logic                func;
    srt_pkg::t_day       day;
    srt_pkg::t_byte      msg_byte;
    logic                has_byte;
    logic                last_byte;
    srt_pkg::t_pos       position;

    modport source (
        output valid, func, day, msg_byte, has_byte, last_byte, position,
        input  ready
    );

    modport sink (
        input  valid, func, day, msg_byte, has_byte, last_byte, position,
        output ready
    );
endinterface

// File: design/srt_out_if.sv
// ----------------------------------------------------------------------------
// srt_out_if
// Result channel: status, entry day and message bytes with valid/ready.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface srt_out_if;
    logic                valid;
    logic                ready;
    srt_pkg::t_stat      status;
    srt_pkg::t_day       out_day;
    srt_pkg::t_byte      out_byte;
    logic                out_has_byte;
    logic                out_last;
    srt_pkg::t_ecnt      entry_count;

    modport source (
        output valid, status, out_day, out_byte, out_has_byte, out_last, entry_count,
        input  ready
    );

    modport sink (
        input  valid, status, out_day, out_byte, out_has_byte, out_last, entry_count,
        output ready
    );
endinterface

// File: design/srt_ram.sv
// ----------------------------------------------------------------------------
// srt_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module srt_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: design/sorted_reminder_table.sv
// ----------------------------------------------------------------------------
// sorted_reminder_table: day-ordered table of short text entries
// Insert: bytes are taken in IDLE. Commit: COMMIT, then SHIFT walks the order
//   list from the top, one entry per cycle, then EMIT; full or bad day: EMIT.
// Read: RD_CHK, RD_ENT, then MSG_RD, MSG_DATA, EMIT per message byte; a missing
//   entry or empty message goes straight to EMIT; output stalls add to every result.
// Reset (synchronous, active low) empties the table; stores are not cleared.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "sorted_reminder_table_assert.svh"

module sorted_reminder_table (
    input  logic      i_clk,
    input  logic      i_rst_n,
    srt_in_if.sink    i_in,
    srt_out_if.source o_out
);

    localparam logic [2:0] ST_IDLE     = 3'd0;
    localparam logic [2:0] ST_COMMIT   = 3'd1;
    localparam logic [2:0] ST_SHIFT    = 3'd2;
    localparam logic [2:0] ST_RD_CHK   = 3'd3;
    localparam logic [2:0] ST_RD_ENT   = 3'd4;
    localparam logic [2:0] ST_MSG_RD   = 3'd5;
    localparam logic [2:0] ST_MSG_DATA = 3'd6;
    localparam logic [2:0] ST_EMIT     = 3'd7;

    // control state
    logic [2:0]            r_state, n_state;
    srt_pkg::t_cnt         r_count, n_count;
    srt_pkg::t_bp          r_bp, n_bp;
    srt_pkg::t_maddr       r_wbase, n_wbase;
    logic                  r_out_valid, n_out_valid;

    // payload state
    srt_pkg::t_order_entry r_new, n_new;
    srt_pkg::t_idx         r_idx, n_idx;
    srt_pkg::t_pos         r_pos, n_pos;
    srt_pkg::t_maddr       r_rbase, n_rbase;
    srt_pkg::t_day         r_rday, n_rday;
    srt_pkg::t_bp          r_len, n_len;
    srt_pkg::t_bp          r_b, n_b;
    srt_pkg::t_result      r_res, n_res;
    srt_pkg::t_result      r_out, n_out;
    srt_pkg::t_cnt         r_out_cnt, n_out_cnt;

    // memory ports
    logic                  ord_we;
    srt_pkg::t_idx         ord_waddr;
    srt_pkg::t_order_entry ord_wdata;
    srt_pkg::t_idx         ord_raddr;
    srt_pkg::t_order_entry ord_rdata;
    logic                  msg_we;
    srt_pkg::t_maddr       msg_waddr;
    srt_pkg::t_maddr       msg_raddr;
    srt_pkg::t_byte        msg_rdata;

    logic                  in_accept;
    logic                  out_free;

    assign in_accept = i_in.valid && i_in.ready;
    assign out_free  = !r_out_valid || o_out.ready;

    srt_ram #(
        .DEPTH (srt_pkg::MAX_ENTRIES),
        .WIDTH ($bits(srt_pkg::t_order_entry))
    ) u_order_ram (
        .i_clk   (i_clk),
        .i_we    (ord_we),
        .i_waddr (ord_waddr),
        .i_wdata (ord_wdata),
        .i_raddr (ord_raddr),
        .o_rdata (ord_rdata)
    );

    srt_ram #(
        .DEPTH (srt_pkg::MSG_DEPTH),
        .WIDTH (srt_pkg::BYTE_W)
    ) u_msg_ram (
        .i_clk   (i_clk),
        .i_we    (msg_we),
        .i_waddr (msg_waddr),
        .i_wdata (i_in.msg_byte),
        .i_raddr (msg_raddr),
        .o_rdata (msg_rdata)
    );

    assign msg_waddr = r_wbase + srt_pkg::t_maddr'(r_bp);
    assign msg_raddr = r_rbase + srt_pkg::t_maddr'(r_b);

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_bp        = r_bp;
        n_wbase     = r_wbase;
        n_out_valid = r_out_valid && !o_out.ready;
        n_new       = r_new;
        n_idx       = r_idx;
        n_pos       = r_pos;
        n_rbase     = r_rbase;
        n_rday      = r_rday;
        n_len       = r_len;
        n_b         = r_b;
        n_res       = r_res;
        n_out       = r_out;
        n_out_cnt   = r_out_cnt;
        ord_we      = 1'b0;
        ord_waddr   = r_idx;
        ord_wdata   = r_new;
        ord_raddr   = srt_pkg::t_idx'(r_pos);
        msg_we      = 1'b0;

        unique case (r_state)
            ST_IDLE: begin
                if (in_accept) begin
                    if (i_in.func == srt_pkg::FUNC_INSERT) begin
                        msg_we = i_in.has_byte && (r_count < srt_pkg::COUNT_FULL)
                                 && (r_bp < srt_pkg::MSG_CAP);
                        if (msg_we) begin
                            n_bp = r_bp + srt_pkg::t_bp'(1);
                        end
                        if (i_in.last_byte) begin
                            n_new.slot = srt_pkg::t_idx'(r_count);
                            n_new.day  = i_in.day;
                            n_new.len  = n_bp;
                            n_bp       = '0;
                            n_state    = ST_COMMIT;
                        end
                    end else begin
                        n_pos   = i_in.position;
                        n_state = ST_RD_CHK;
                    end
                end
            end

            ST_COMMIT: begin
                n_res = '{status: srt_pkg::STAT_OK, day: '0, data: '0, has: 1'b0,
                          last: 1'b1};
                if (r_count >= srt_pkg::COUNT_FULL) begin
                    n_res.status = srt_pkg::STAT_FULL;
                    n_state      = ST_EMIT;
                end else if (r_new.day == srt_pkg::DAY_NONE) begin
                    n_res.status = srt_pkg::STAT_BAD_DAY;
                    n_state      = ST_EMIT;
                end else begin
                    // start the walk at the top of the list
                    n_idx     = srt_pkg::t_idx'(r_count);
                    ord_raddr = n_idx - srt_pkg::t_idx'(1);
                    n_state   = ST_SHIFT;
                end
            end

            ST_SHIFT: begin
                ord_we    = 1'b1;
                ord_waddr = r_idx;
                if (r_idx == '0 || ord_rdata.day < r_new.day) begin
                    // slot found: drop the new record here
                    ord_wdata = r_new;
                    n_count   = r_count + srt_pkg::t_cnt'(1);
                    n_wbase   = r_wbase + srt_pkg::t_maddr'(srt_pkg::MAX_MSG);
                    n_state   = ST_EMIT;
                end else begin
                    // move the later-or-equal record up one place
                    ord_wdata = ord_rdata;
                    n_idx     = r_idx - srt_pkg::t_idx'(1);
                    ord_raddr = n_idx - srt_pkg::t_idx'(1);
                end
            end

            ST_RD_CHK: begin
                if (int'(r_pos) >= int'(r_count)) begin
                    n_res = '{status: srt_pkg::STAT_NO_ENTRY, day: '0, data: '0,
                              has: 1'b0, last: 1'b1};
                    n_state = ST_EMIT;
                end else begin
                    n_state = ST_RD_ENT;
                end
            end

            ST_RD_ENT: begin
                n_rbase = srt_pkg::t_maddr'(ord_rdata.slot * srt_pkg::MAX_MSG);
                n_rday  = ord_rdata.day;
                n_len   = ord_rdata.len;
                n_b     = '0;
                if (ord_rdata.len == '0) begin
                    n_res = '{status: srt_pkg::STAT_OK, day: ord_rdata.day, data: '0,
                              has: 1'b0, last: 1'b1};
                    n_state = ST_EMIT;
                end else begin
                    n_state = ST_MSG_RD;
                end
            end

            ST_MSG_RD: begin
                n_state = ST_MSG_DATA;
            end

            ST_MSG_DATA: begin
                n_b   = r_b + srt_pkg::t_bp'(1);
                n_res = '{status: srt_pkg::STAT_OK, day: r_rday, data: msg_rdata,
                          has: 1'b1, last: (n_b == r_len)};
                n_state = ST_EMIT;
            end

            ST_EMIT: begin
                if (out_free) begin
                    n_out       = r_res;
                    n_out_cnt   = r_count;
                    n_out_valid = 1'b1;
                    n_state     = r_res.last ? ST_IDLE : ST_MSG_RD;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_bp        <= '0;
            r_wbase     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_bp        <= n_bp;
            r_wbase     <= n_wbase;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_new     <= n_new;
        r_idx     <= n_idx;
        r_pos     <= n_pos;
        r_rbase   <= n_rbase;
        r_rday    <= n_rday;
        r_len     <= n_len;
        r_b       <= n_b;
        r_res     <= n_res;
        r_out     <= n_out;
        r_out_cnt <= n_out_cnt;
    end

    assign i_in.ready         = (r_state == ST_IDLE);
    assign o_out.valid        = r_out_valid;
    assign o_out.status       = r_out.status;
    assign o_out.out_day      = r_out.day;
    assign o_out.out_byte     = r_out.data;
    assign o_out.out_has_byte = r_out.has;
    assign o_out.out_last     = r_out.last;
    assign o_out.entry_count  = srt_pkg::t_ecnt'(r_out_cnt);

    `SRT_ASSERT_SAME(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= srt_pkg::COUNT_FULL)
    `SRT_ASSERT_SAME(a_bp_bound, i_clk, i_rst_n, 1'b1, r_bp <= srt_pkg::MSG_CAP)
    `SRT_ASSERT_SAME(a_shift_idx, i_clk, i_rst_n, r_state == ST_SHIFT,
                     srt_pkg::t_cnt'(r_idx) <= r_count)
    `SRT_ASSERT_SAME(a_wbase_track, i_clk, i_rst_n, 1'b1,
                     r_wbase == srt_pkg::t_maddr'(r_count * srt_pkg::MAX_MSG))
    `SRT_ASSERT_NEXT(a_count_step, i_clk, i_rst_n, r_state != ST_SHIFT,
                     r_count == $past(r_count))

endmodule
